/* rtl/core/qrs_pkg.sv */
// Types, constants and widths shared by the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 50;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
    } t_qrs_in;

    typedef struct packed {
        logic        [1:0]  root_count;
        logic signed [31:0] single_root;
        logic signed [31:0] minus_root;
        logic signed [31:0] plus_root;
        logic               degenerate;
        logic               saturated;
    } t_qrs_out;

    // Setup held alongside the computation as it travels down a chain.
    typedef struct packed {
        logic              quad;
        logic              degen;
        logic [1:0]        count;
        logic              neg_den;
        logic [16:0]       den_mag;
        logic signed [33:0] nb;
    } t_qrs_ctl;

    function automatic logic [32:0] qrs_clip(input logic signed [50:0] v);
        logic [32:0] r;
        if (v > 51'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -51'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/quadratic_root_solver_core.sv */
// Top level of the pipelined quadratic root solver.
// Takes one coefficient set per clock (busy is always low) and raises o_done for it once the
// set has passed, in order, through two setup stages, a chain of 32 square-root cells (two
// radicand bits each), one numerator stage, a chain of 50 divider cells (one quotient bit
// each) and the output register, which also restores the sign and clips. Results cannot be
// held off, so the pipeline never stalls.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_core
    import qrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_qrs_in  i_item,
    output logic          o_done,
    output t_qrs_out      o_result
);

    assign busy = 1'b0;

    // stage 1: products
    logic               r_v1;
    logic signed [15:0] r_a1, r_b1;
    logic signed [31:0] r_bb1, r_ac1;
    logic signed [15:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start;
        r_a1  <= i_item.coef_a;
        r_b1  <= i_item.coef_b;
        r_c1  <= i_item.coef_c;
        r_bb1 <= i_item.coef_b * i_item.coef_b;
        r_ac1 <= i_item.coef_a * i_item.coef_c;
    end

    // stage 2: discriminant and control
    logic               r_v2;
    t_qrs_ctl           r_ctl2;
    logic signed [34:0] r_d2;
    logic signed [33:0] r_lnum2;
    t_qrs_ctl           n_ctl2;
    logic signed [34:0] n_d;

    always_comb begin
        n_d = 35'(r_bb1) - (35'(r_ac1) <<< 2);
        n_ctl2.quad  = (r_a1 != 16'sd0);
        n_ctl2.degen = (r_a1 == 16'sd0) && (r_b1 == 16'sd0);
        if (r_a1 != 16'sd0) begin
            n_ctl2.count = (n_d < 0) ? 2'd0 : ((n_d == 0) ? 2'd1 : 2'd2);
            n_ctl2.neg_den = r_a1[15];
            n_ctl2.den_mag = r_a1[15] ? 17'(-(18'sd2 * 18'(r_a1)))
                                      : 17'(18'sd2 * 18'(r_a1));
        end else begin
            n_ctl2.count = n_ctl2.degen ? 2'd0 : 2'd1;
            n_ctl2.neg_den = r_b1[15];
            n_ctl2.den_mag = r_b1[15] ? 17'(-17'(r_b1)) : 17'(17'(r_b1));
        end
        n_ctl2.nb = -(34'(r_b1) <<< 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_ctl2  <= n_ctl2;
        r_d2    <= n_d;
        r_lnum2 <= -(34'(r_c1) <<< 16);
    end

    // square-root chain on D * 2^30
    logic [32:0][63:0] w_rad;
    logic [32:0][33:0] w_rem;
    logic [32:0][31:0] w_root;
    logic [32:0]       w_sv;
    t_qrs_ctl [32:0]   w_sc;
    logic signed [33:0] r_lnum_d [SQRT_STEPS];

    assign w_sv[0]   = r_v2;
    assign w_sc[0]   = r_ctl2;
    assign w_rad[0]  = (r_ctl2.quad && r_d2 > 0) ? (64'(r_d2) << 30) : 64'd0;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    always_ff @(posedge i_clk) begin
        r_lnum_d[0] <= r_lnum2;
        for (int k = 1; k < SQRT_STEPS; k++) r_lnum_d[k] <= r_lnum_d[k-1];
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_sv[g]),
            .i_ctl  (w_sc[g]),
            .i_rad  (w_rad[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_vld  (w_sv[g+1]),
            .o_ctl  (w_sc[g+1]),
            .o_rad  (w_rad[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    // stage: numerators in sign/magnitude
    logic                    r_v3;
    t_qrs_ctl                r_ctl3;
    logic [2:0]              r_neg3;
    logic [2:0][49:0]        r_num3;
    logic signed [34:0]      n_s;
    logic [2:0][34:0]        n_n;

    always_comb begin
        n_s = 35'(w_root[SQRT_STEPS]) <<< 1;
        if (w_sc[SQRT_STEPS].quad) begin
            n_n[0] = 35'(w_sc[SQRT_STEPS].nb);
            n_n[1] = 35'(w_sc[SQRT_STEPS].nb) - n_s;
            n_n[2] = 35'(w_sc[SQRT_STEPS].nb) + n_s;
        end else begin
            n_n[0] = 35'(r_lnum_d[SQRT_STEPS-1]);
            n_n[1] = '0;
            n_n[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= w_sv[SQRT_STEPS];
        r_ctl3 <= w_sc[SQRT_STEPS];
        for (int k = 0; k < 3; k++) begin
            r_neg3[k] <= n_n[k][34] ^ w_sc[SQRT_STEPS].neg_den;
            r_num3[k] <= n_n[k][34] ? 50'(-$signed(n_n[k])) : 50'(n_n[k]);
        end
    end

    // divider chain
    logic [DIV_STEPS:0]             w_dv;
    t_qrs_ctl [DIV_STEPS:0]         w_dc;
    logic [DIV_STEPS:0][2:0]        w_neg;
    logic [DIV_STEPS:0][2:0][49:0]  w_num;
    logic [DIV_STEPS:0][2:0][16:0]  w_drem;
    logic [DIV_STEPS:0][2:0][49:0]  w_quo;

    assign w_dv[0]   = r_v3;
    assign w_dc[0]   = r_ctl3;
    assign w_neg[0]  = r_neg3;
    assign w_num[0]  = r_num3;
    assign w_drem[0] = '0;
    assign w_quo[0]  = '0;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_dv[g]),
            .i_ctl  (w_dc[g]),
            .i_neg  (w_neg[g]),
            .i_num  (w_num[g]),
            .i_rem  (w_drem[g]),
            .i_quo  (w_quo[g]),
            .o_vld  (w_dv[g+1]),
            .o_ctl  (w_dc[g+1]),
            .o_neg  (w_neg[g+1]),
            .o_num  (w_num[g+1]),
            .o_rem  (w_drem[g+1]),
            .o_quo  (w_quo[g+1])
        );
    end

    // sign restore and clip
    logic [2:0][32:0] n_clip;
    t_qrs_ctl         w_fc;

    assign w_fc = w_dc[DIV_STEPS];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_clip[k] = qrs_clip(w_neg[DIV_STEPS][k]
                ? -$signed({1'b0, w_quo[DIV_STEPS][k]})
                :  $signed({1'b0, w_quo[DIV_STEPS][k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= w_dv[DIV_STEPS];
        o_result.root_count <= w_fc.count;
        o_result.degenerate <= w_fc.degen;
        if (w_fc.degen) begin
            o_result.single_root <= '0;
            o_result.minus_root  <= '0;
            o_result.plus_root   <= '0;
            o_result.saturated   <= 1'b0;
        end else if (!w_fc.quad || w_fc.count == 2'd0) begin
            o_result.single_root <= n_clip[0][31:0];
            o_result.minus_root  <= '0;
            o_result.plus_root   <= '0;
            o_result.saturated   <= n_clip[0][32];
        end else begin
            o_result.single_root <= n_clip[0][31:0];
            o_result.minus_root  <= n_clip[1][31:0];
            o_result.plus_root   <= n_clip[2][31:0];
            o_result.saturated   <= n_clip[0][32] | n_clip[1][32] | n_clip[2][32];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/qrs_sqrt_cell.sv */
// One restoring-square-root cell: retires two radicand bits per clock.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire t_qrs_ctl    i_ctl,
    input  wire logic [63:0] i_rad,
    input  wire logic [33:0] i_rem,
    input  wire logic [31:0] i_root,
    output logic             o_vld,
    output t_qrs_ctl         o_ctl,
    output logic [63:0]      o_rad,
    output logic [33:0]      o_rem,
    output logic [31:0]      o_root
);

    logic [33:0] n_trial;
    logic [33:0] n_sub;

    always_comb begin
        n_trial = {i_rem[31:0], i_rad[63:62]};
        n_sub   = {i_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_ctl <= i_ctl;
        o_rad <= {i_rad[61:0], 2'b00};
        if (n_trial >= n_sub) begin
            o_rem  <= n_trial - n_sub;
            o_root <= {i_root[30:0], 1'b1};
        end else begin
            o_rem  <= n_trial;
            o_root <= {i_root[30:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

/* rtl/core/qrs_div_cell.sv */
// One restoring-divide cell: three unsigned quotients, one bit per clock.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell
    import qrs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire t_qrs_ctl         i_ctl,
    input  wire logic [2:0]       i_neg,
    input  wire logic [2:0][49:0] i_num,
    input  wire logic [2:0][16:0] i_rem,
    input  wire logic [2:0][49:0] i_quo,
    output logic                  o_vld,
    output t_qrs_ctl              o_ctl,
    output logic [2:0]            o_neg,
    output logic [2:0][49:0]      o_num,
    output logic [2:0][16:0]      o_rem,
    output logic [2:0][49:0]      o_quo
);

    logic [2:0][17:0] n_trial;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_trial[k] = {i_rem[k], i_num[k][49]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_ctl <= i_ctl;
        o_neg <= i_neg;
        for (int k = 0; k < 3; k++) begin
            o_num[k] <= {i_num[k][48:0], 1'b0};
            if (n_trial[k] >= {1'b0, i_ctl.den_mag}) begin
                o_rem[k] <= 17'(n_trial[k] - {1'b0, i_ctl.den_mag});
                o_quo[k] <= {i_quo[k][48:0], 1'b1};
            end else begin
                o_rem[k] <= n_trial[k][16:0];
                o_quo[k] <= {i_quo[k][48:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/qrs_checker.sv */
// Port-level checks for the quadratic root solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker
    import qrs_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     busy,
    input wire logic     o_done,
    input wire t_qrs_out o_result
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.root_count != 2'd3) else $error("bad root count");

    a_degen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |->
        (o_result.root_count == 2'd0 && !o_result.saturated && o_result.single_root == 0))
        else $error("degenerate result not clean");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.root_count == 2'd0) |->
        (o_result.minus_root == 0 && o_result.plus_root == 0))
        else $error("roots set with no real root");

    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.root_count == 2'd1 && o_result.plus_root != 0) |->
        (o_result.minus_root == o_result.plus_root))
        else $error("double root mismatch");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import qrs_pkg::*;

    localparam int LATENCY    = 86;
    localparam int N_RANDOM   = 1430;
    localparam int STALL_MAX  = 2000;
    localparam int N_STIM     = 20;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_qrs_in  i_item;
    logic     o_done;
    t_qrs_out o_result;

    quadratic_root_solver_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    t_qrs_out roots_pending[$];
    int       n_errors;
    int       n_sent;
    int       n_seen;
    int       n_degen;
    int       n_linear;
    int       n_count[3];
    int       n_sat;
    int       idle_cycles;
    bit       has_typed[N_STIM];
    t_qrs_in  stim_in[N_STIM];
    t_qrs_out stim_out[N_STIM];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip_q16(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_qrs_out solve_roots(input t_qrs_in x);
        t_qrs_out r;
        longint   a;
        longint   b;
        longint   c;
        longint   disc;
        longint   den;
        longint   nb;
        longint   s;
        logic     sat;
        a   = x.coef_a;
        b   = x.coef_b;
        c   = x.coef_c;
        r   = '0;
        sat = 1'b0;
        if (a == 0) begin
            if (b == 0) begin
                r.degenerate = 1'b1;
            end else begin
                r.root_count  = 2'd1;
                r.single_root = clip_q16((-c * 65536) / b, sat);
            end
        end else begin
            disc = b * b - 4 * a * c;
            den  = 2 * a;
            nb   = -b * 65536;
            r.single_root = clip_q16(nb / den, sat);
            if (disc >= 0) begin
                s = 0;
                if (disc > 0) begin
                    s = 2 * longint'(isqrt(64'(disc) << 30));
                    r.root_count = 2'd2;
                end else begin
                    r.root_count = 2'd1;
                end
                r.minus_root = clip_q16((nb - s) / den, sat);
                r.plus_root  = clip_q16((nb + s) / den, sat);
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic t_qrs_out typed_out(input logic [1:0] cnt, input logic signed [31:0] sr,
                                           input logic signed [31:0] mr,
                                           input logic signed [31:0] pr,
                                           input logic dg, input logic st);
        t_qrs_out r;
        r.root_count  = cnt;
        r.single_root = sr;
        r.minus_root  = mr;
        r.plus_root   = pr;
        r.degenerate  = dg;
        r.saturated   = st;
        return r;
    endfunction

    task automatic add_row(input int k, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input bit typed, input t_qrs_out r);
        stim_in[k]   = '{coef_a: a, coef_b: b, coef_c: c};
        has_typed[k] = typed;
        stim_out[k]  = r;
    endtask

    task automatic send_beat(input t_qrs_in x, input t_qrs_out want, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        roots_pending.push_back(want);
        n_sent++;
        if (want.degenerate) n_degen++;
        else if (x.coef_a == 0) n_linear++;
        else n_count[want.root_count]++;
        if (want.saturated) n_sat++;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'(int'($urandom_range(0, 16)) - 8);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            3: return 16'($signed(16'($urandom)) >>> $urandom_range(0, 12));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_qrs_out want;
        if (i_rst_n && o_done) begin
            n_seen++;
            if (roots_pending.size() == 0) begin
                $error("result beat with no expectation waiting");
                n_errors++;
            end else begin
                want = roots_pending.pop_front();
                if (o_result.root_count !== want.root_count) begin
                    $error("root_count: expected %0d, got %0d",
                           want.root_count, o_result.root_count);
                    n_errors++;
                end
                if (o_result.single_root !== want.single_root) begin
                    $error("single_root: expected %0d, got %0d",
                           want.single_root, o_result.single_root);
                    n_errors++;
                end
                if (o_result.minus_root !== want.minus_root) begin
                    $error("minus_root: expected %0d, got %0d",
                           want.minus_root, o_result.minus_root);
                    n_errors++;
                end
                if (o_result.plus_root !== want.plus_root) begin
                    $error("plus_root: expected %0d, got %0d",
                           want.plus_root, o_result.plus_root);
                    n_errors++;
                end
                if (o_result.degenerate !== want.degenerate) begin
                    $error("degenerate: expected %0d, got %0d",
                           want.degenerate, o_result.degenerate);
                    n_errors++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, o_result.saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_MAX) begin
            $display("quadratic_root_solver_core verification failed");
            $finish;
        end
    end

    initial begin
        t_qrs_in x;
        int      drain;
        n_errors    = 0;
        n_sent      = 0;
        n_seen      = 0;
        n_degen     = 0;
        n_linear    = 0;
        n_count     = '{0, 0, 0};
        n_sat       = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;

        add_row(0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
                typed_out(2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0));
        add_row(1,  16'h0000, 16'h0000, 16'h7FFF, 1'b1,
                typed_out(2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0));
        add_row(2,  16'h0000, 16'h0100, 16'hFF00, 1'b1,
                typed_out(2'd1, 32'sh10000, 32'sd0, 32'sd0, 1'b0, 1'b0));
        add_row(3,  16'h0000, 16'h0001, 16'h8000, 1'b1,
                typed_out(2'd1, 32'sh7FFF_FFFF, 32'sd0, 32'sd0, 1'b0, 1'b1));
        add_row(4,  16'h0000, 16'h0001, 16'h7FFF, 1'b1,
                typed_out(2'd1, 32'sh8001_0000, 32'sd0, 32'sd0, 1'b0, 1'b0));
        add_row(5,  16'h0100, 16'h0000, 16'hFF00, 1'b1,
                typed_out(2'd2, 32'sd0, 32'shFFFF_0000, 32'sh10000, 1'b0, 1'b0));
        add_row(6,  16'h0100, 16'h0000, 16'h0100, 1'b1,
                typed_out(2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
        add_row(7,  16'h0100, 16'hFE00, 16'h0100, 1'b1,
                typed_out(2'd1, 32'sh10000, 32'sh10000, 32'sh10000, 1'b0, 1'b0));
        add_row(8,  16'h0001, 16'h7FFF, 16'h0000, 1'b0, '0);
        add_row(9,  16'h0001, 16'h8000, 16'h8000, 1'b0, '0);
        add_row(10, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        add_row(11, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
        add_row(12, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        add_row(13, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, '0);
        add_row(14, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0, '0);
        add_row(15, 16'h0001, 16'h0000, 16'h8000, 1'b0, '0);
        add_row(16, 16'hFF00, 16'h0300, 16'hFE00, 1'b0, '0);
        add_row(17, 16'h0200, 16'hFB00, 16'h0300, 1'b0, '0);
        add_row(18, 16'h0000, 16'hFFFF, 16'h0001, 1'b0, '0);
        add_row(19, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_STIM; k++) begin
            send_beat(stim_in[k], has_typed[k] ? stim_out[k] : solve_roots(stim_in[k]), 1'b1);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            x.coef_a = rand_coef();
            x.coef_b = rand_coef();
            x.coef_c = rand_coef();
            send_beat(x, solve_roots(x), k < N_RANDOM - 200);
        end
        start <= 1'b0;

        drain = 0;
        while (roots_pending.size() != 0 && drain < 20 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY) @(posedge i_clk);

        $display("%0d coefficient sets, %0d results: %0d degenerate, %0d linear, quadratic",
                 n_sent, n_seen, n_degen, n_linear);
        $display("  with 0/1/2 roots %0d/%0d/%0d, %0d clipped",
                 n_count[0], n_count[1], n_count[2], n_sat);
        if (n_errors == 0 && roots_pending.size() == 0) begin
            $display("quadratic_root_solver_core verification clean");
        end else begin
            if (roots_pending.size() != 0) $error("%0d results never arrived", roots_pending.size());
            $display("quadratic_root_solver_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver_core.sv
rtl/core/qrs_checker.sv
verif/tb_top.sv
